// ===== hdl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsd_pkg: shared constants for the running statistic decimator.
// Holds request codes, statistic modes, register indexes and widths.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 32;
    localparam int OUT_BITS       = 48;

    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_FINISH  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    localparam logic [3:0] MODE_NONE   = 4'd0;
    localparam logic [3:0] MODE_MAX    = 4'd1;
    localparam logic [3:0] MODE_MIN    = 4'd2;
    localparam logic [3:0] MODE_AVG    = 4'd3;
    localparam logic [3:0] MODE_SUM    = 4'd4;
    localparam logic [3:0] MODE_IMAX   = 4'd6;
    localparam logic [3:0] MODE_IMIN   = 4'd7;
    localparam logic [3:0] MODE_THRESH = 4'd8;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_SUMMARY = 3'd1;
    localparam logic [2:0] REG_THRESH  = 3'd2;
    localparam logic [2:0] REG_DECIM   = 3'd3;
    localparam logic [2:0] REG_GAIN    = 3'd4;

endpackage

// ===== hdl/running_statistic_decimator.sv =====
// ----------------------------------------------------------------------------
// running_statistic_decimator
// Scales samples, tracks a running statistic and emits window averages or a
// run summary, with one shared 64-bit restoring divider.
// ----------------------------------------------------------------------------
// Channel        | Direction | Content
// s_axis         | in        | tdata: sample_value[31:0]; tuser: req_type[1:0]
// m_axis         | out       | tdata: out_value[47:0]; tuser: out_kind
// cfg            | in        | i_cfg_addr register index, i_cfg_data value
//
// A sample passes the multiply, scale, update and window states before the
// next possible transfer, plus the divider for each division it needs (average
// mode, and window close without summary mode); the 64-step divider sets the
// rate. Finish and restart items pass the multiply state only. The input is
// ready only while the sequencer is idle; an item that produces a result waits
// in its last step while an earlier result is still held in the output register.
// Reset is synchronous and active low; it restores the registers' defaults.
// ----------------------------------------------------------------------------
module running_statistic_decimator #(
    parameter int VALUE_BITS = rsd_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = rsd_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_value[31:0]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_value[47:0]
    output logic        m_axis_tuser,   // out_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    localparam int OB = rsd_pkg::OUT_BITS;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
    localparam logic signed [63:0] OUT_MAX = 64'sd1 <<< (OB - 1);
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [63:0] IDX_LIM = 64'((OUT_MAX - 64'sd1) >>> 16);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCALE, S_UPD, S_DIV, S_WIN, S_OUT
    } t_state;

    t_state r_state;

    logic [3:0]  r_mode;
    logic        r_summary;
    logic signed [31:0] r_thresh;
    logic [15:0] r_decim;
    logic [31:0] r_gain;

    logic [1:0]  r_req;
    logic signed [31:0] r_sample;
    logic signed [63:0] r_prod;
    logic signed [VALUE_BITS-1:0] r_v;
    logic signed [VALUE_BITS-1:0] r_ext;
    logic signed [63:0] r_rsum;
    logic [COUNT_BITS-1:0] r_idx;
    logic signed [OB-1:0] r_stat;
    logic signed [VALUE_BITS-1:0] r_prev;
    logic        r_have_prev;
    logic        r_crossed;
    logic signed [63:0] r_wsum;
    logic [16:0] r_wcnt;
    logic        r_win_div;

    // shared divider: |num| / den, sign applied at the end
    logic [63:0] r_dnum;
    logic [63:0] r_dden;
    logic [63:0] r_drem;
    logic        r_dneg;
    logic [6:0]  r_dcnt;

    logic        r_ovalid;
    logic signed [OB-1:0] r_oval;
    logic        r_okind;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_okind;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return S64_MAX;
        if (a[63] && b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    function automatic logic signed [OB-1:0] sat_out(input logic signed [63:0] x);
        if (x > OUT_MAX - 64'sd1) return OB'(OUT_MAX - 64'sd1);
        if (x < -OUT_MAX) return OB'(-OUT_MAX);
        return OB'(x);
    endfunction

    function automatic logic signed [OB-1:0] idx_q16(input logic [63:0] n);
        if (n > IDX_LIM) return OB'(OUT_MAX - 64'sd1);
        return OB'(n << 16);
    endfunction

    logic signed [63:0] w_q;
    logic signed [63:0] w_sv;
    logic [64:0] w_trial;
    logic signed [63:0] w_wsum_n;
    logic [16:0] w_wcnt_n;
    logic signed [63:0] w_v64;
    logic [COUNT_BITS-1:0] w_idx_n;
    logic        w_first;
    logic        w_cross;
    logic signed [63:0] w_rsum_n;
    logic        w_out_free;
    logic        w_out_load;

    always_comb begin
        // floor of the Q16.16 product, then saturate
        w_q = r_prod >>> 16;
        if (w_q > VMAX) w_sv = VMAX;
        else if (w_q < VMIN) w_sv = VMIN;
        else w_sv = w_q;
        w_trial  = {r_drem[63:0], r_dnum[63]} - {1'b0, r_dden};
        w_v64    = 64'(r_v);
        w_first  = (r_idx == '0);
        w_idx_n  = (r_idx != CMAX) ? r_idx + 1'b1 : r_idx;
        w_rsum_n = sat_add(r_rsum, w_v64);
        w_cross  = (64'(r_prev) < 64'(r_thresh) && 64'(r_thresh) <= w_v64) ||
                   (64'(r_prev) > 64'(r_thresh) && 64'(r_thresh) >= w_v64);
        w_wsum_n = sat_add(r_wsum, 64'(r_stat));
        w_wcnt_n = (r_wcnt != 17'h1FFFF) ? r_wcnt + 1'b1 : r_wcnt;
        // The output register is free when empty or when its transfer completes now.
        w_out_free = !r_ovalid || m_axis_tready;
        w_out_load = w_out_free &&
                     (((r_state == S_MUL) && (r_req == rsd_pkg::REQ_FINISH) && r_summary) ||
                      ((r_state == S_DIV) && (r_dcnt == 7'd64) && r_win_div));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= rsd_pkg::MODE_NONE;
            r_summary <= 1'b0;
            r_thresh <= '0;
            r_decim <= '0;
            r_gain <= 32'd65536;
            r_ovalid <= 1'b0;
            r_rsum <= '0; r_idx <= '0; r_stat <= '0; r_prev <= '0; r_ext <= '0;
            r_have_prev <= 1'b0; r_crossed <= 1'b0; r_wsum <= '0; r_wcnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_addr)
                    rsd_pkg::REG_MODE:    r_mode <= i_cfg_data[3:0];
                    rsd_pkg::REG_SUMMARY: r_summary <= i_cfg_data[0];
                    rsd_pkg::REG_THRESH:  r_thresh <= i_cfg_data;
                    rsd_pkg::REG_DECIM:   r_decim <= i_cfg_data[15:0];
                    rsd_pkg::REG_GAIN:    r_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_req <= s_axis_tuser;
                        r_sample <= s_axis_tdata;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= r_sample * $signed({1'b0, r_gain});
                    case (r_req)
                        rsd_pkg::REQ_RESTART: begin
                            r_rsum <= '0; r_idx <= '0; r_stat <= '0; r_prev <= '0;
                            r_ext <= '0; r_have_prev <= 1'b0; r_crossed <= 1'b0;
                            r_wsum <= '0; r_wcnt <= '0;
                            r_state <= S_IDLE;
                        end
                        rsd_pkg::REQ_FINISH: begin
                            if (!r_summary) begin
                                r_state <= S_IDLE;
                            end else if (w_out_free) begin
                                r_oval <= r_stat; r_okind <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        rsd_pkg::REQ_SAMPLE: r_state <= S_SCALE;
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SCALE: begin
                    r_v <= VALUE_BITS'(w_sv);
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_idx <= w_idx_n;
                    case (r_mode)
                        rsd_pkg::MODE_MAX, rsd_pkg::MODE_IMAX: begin
                            r_state <= S_WIN;
                            if (w_first || r_v > r_ext) begin
                                r_ext <= r_v;
                                r_stat <= (r_mode == rsd_pkg::MODE_MAX) ? OB'(w_v64)
                                        : idx_q16(64'(w_idx_n));
                            end
                        end
                        rsd_pkg::MODE_MIN, rsd_pkg::MODE_IMIN: begin
                            r_state <= S_WIN;
                            if (w_first || r_v < r_ext) begin
                                r_ext <= r_v;
                                r_stat <= (r_mode == rsd_pkg::MODE_MIN) ? OB'(w_v64)
                                        : idx_q16(64'(w_idx_n));
                            end
                        end
                        rsd_pkg::MODE_AVG: begin
                            r_rsum <= w_rsum_n;
                            r_dneg <= w_rsum_n[63];
                            r_dnum <= w_rsum_n[63] ? 64'(-w_rsum_n) : w_rsum_n;
                            r_dden <= 64'(w_idx_n);
                            r_drem <= '0; r_dcnt <= '0; r_win_div <= 1'b0;
                            r_state <= S_DIV;
                        end
                        rsd_pkg::MODE_SUM: begin
                            r_state <= S_WIN;
                            r_rsum <= w_rsum_n;
                            r_stat <= sat_out(w_rsum_n);
                        end
                        rsd_pkg::MODE_THRESH: begin
                            r_state <= S_WIN;
                            if (!r_crossed) begin
                                r_prev <= r_v;
                                if (!r_have_prev) r_have_prev <= 1'b1;
                                else begin
                                    r_crossed <= w_cross;
                                    if (w_cross) r_stat <= idx_q16(64'(w_idx_n));
                                end
                            end
                        end
                        default: begin
                            r_state <= S_WIN;
                            r_stat <= OB'(w_v64);
                        end
                    endcase
                end
                S_DIV: begin
                    // one quotient bit a cycle; quotient shifts into r_dnum
                    if (r_dcnt == 7'd64) begin
                        if (r_win_div) begin
                            if (w_out_free) begin
                                r_oval <= sat_out(r_dneg ? 64'(-r_dnum) : r_dnum);
                                r_okind <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_stat <= sat_out(r_dneg ? 64'(-r_dnum) : r_dnum);
                            r_state <= S_WIN;
                        end
                    end else begin
                        if (!w_trial[64]) begin
                            r_drem <= w_trial[63:0];
                            r_dnum <= {r_dnum[62:0], 1'b1};
                        end else begin
                            r_drem <= {r_drem[62:0], r_dnum[63]};
                            r_dnum <= {r_dnum[62:0], 1'b0};
                        end
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_WIN: begin
                    if (!r_summary && (r_wcnt >= {1'b0, r_decim})) begin
                        r_wsum <= '0; r_wcnt <= '0;
                        r_dneg <= w_wsum_n[63];
                        r_dnum <= w_wsum_n[63] ? 64'(-w_wsum_n) : w_wsum_n;
                        r_dden <= 64'(w_wcnt_n);
                        r_drem <= '0; r_dcnt <= '0; r_win_div <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_IDLE;
                        if (!r_summary) begin
                            r_wsum <= w_wsum_n; r_wcnt <= w_wcnt_n;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
